### hdl/lcs_pkg.sv
// Shared types, constants and helpers for the luma contrast stretch block.
package lcs_pkg;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned LUMA_W   = 18;
  localparam int unsigned CC_W     = 3;
  localparam int unsigned GRAY_W   = 8;
  localparam int unsigned PROD_W   = 16;
  // Divider datapath: offset*510 + span stays below 2^27, divisor<<8 below 2^28.
  localparam int unsigned DIV_W    = 28;
  localparam int unsigned STEP_W   = 3;

  // APB register file
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_CHANNEL_COUNT = 1'b0;

  localparam logic [CC_W-1:0] CC_RESET      = 3'd3;
  localparam logic [CC_W-1:0] CC_GRAY       = 3'd1;
  localparam logic [CC_W-1:0] CC_GRAY_ALPHA = 3'd2;
  localparam logic [CC_W-1:0] CC_RGB        = 3'd3;
  localparam logic [CC_W-1:0] CC_RGBA       = 3'd4;

  localparam logic KIND_GATHER = 1'b0;
  localparam logic KIND_MAP    = 1'b1;

  localparam logic [LUMA_W-1:0] WEIGHT_R = 18'd299;
  localparam logic [LUMA_W-1:0] WEIGHT_G = 18'd587;
  localparam logic [LUMA_W-1:0] WEIGHT_B = 18'd114;

  localparam logic [LUMA_W-1:0] LUMA_ALL_ONES = '1;
  localparam logic [DIV_W-1:0]  MAP_SCALE     = 28'd510;  // 2 * 255
  localparam logic [GRAY_W-1:0] GRAY_MAX      = 8'hFF;

  typedef struct packed {
    logic              kind;
    logic              frame_start;
    logic [LUMA_W-1:0] luma;
  } lcs_entry_t;

  // floor(x / 255), exact for x < 65280
  function automatic logic [SAMPLE_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[PROD_W-1:SAMPLE_W]};
    return t[PROD_W-1:SAMPLE_W];
  endfunction

endpackage

### hdl/lcs_if.sv
// Valid/ready stream interfaces for pixel words and gray words.
interface lcs_pix_if import lcs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic                frame_start;
  logic [SAMPLE_W-1:0] sample0;
  logic [SAMPLE_W-1:0] sample1;
  logic [SAMPLE_W-1:0] sample2;
  logic [SAMPLE_W-1:0] sample3;

  modport source (output valid, kind, frame_start, sample0, sample1, sample2, sample3,
                  input ready);
  modport sink   (input valid, kind, frame_start, sample0, sample1, sample2, sample3,
                  output ready);
endinterface

interface lcs_gray_if import lcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GRAY_W-1:0] gray_level;

  modport source (output valid, gray_level, input ready);
  modport sink   (input valid, gray_level, output ready);
endinterface

### hdl/lcs_front.sv
// Front end: takes pixel words, premultiplies alpha and forms luma for the queue.
module lcs_front import lcs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CC_W-1:0] channel_count_i,
  lcs_pix_if.sink         pix_i,
  input  logic            full_i,
  output logic            push_o,
  output lcs_entry_t      push_data_o
);

  logic                s1_valid_q;
  logic                s1_kind_q;
  logic                s1_start_q;
  logic [SAMPLE_W-1:0] s1_raw_q  [3];
  logic [PROD_W-1:0]   s1_prod_q [3];

  logic [SAMPLE_W-1:0] alpha;
  logic [SAMPLE_W-1:0] r, g, b;
  logic                s1_take;

  assign push_o      = s1_valid_q && !full_i;
  assign pix_i.ready = !s1_valid_q || !full_i;
  assign s1_take     = pix_i.valid && pix_i.ready;

  // gray+alpha carries alpha in sample1
  assign alpha = (channel_count_i == CC_GRAY_ALPHA) ? pix_i.sample1 : pix_i.sample3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_take) begin
      s1_valid_q <= 1'b1;
    end else if (push_o) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take) begin
      s1_kind_q    <= pix_i.kind;
      s1_start_q   <= pix_i.frame_start;
      s1_raw_q[0]  <= pix_i.sample0;
      s1_raw_q[1]  <= pix_i.sample1;
      s1_raw_q[2]  <= pix_i.sample2;
      s1_prod_q[0] <= pix_i.sample0 * alpha;
      s1_prod_q[1] <= pix_i.sample1 * pix_i.sample3;
      s1_prod_q[2] <= pix_i.sample2 * pix_i.sample3;
    end
  end

  always_comb begin
    r = '0;
    g = '0;
    b = '0;
    unique case (channel_count_i)
      CC_GRAY: begin
        r = s1_raw_q[0];
        g = s1_raw_q[0];
        b = s1_raw_q[0];
      end
      CC_GRAY_ALPHA: begin
        r = div255(s1_prod_q[0]);
        g = r;
        b = r;
      end
      CC_RGB: begin
        r = s1_raw_q[0];
        g = s1_raw_q[1];
        b = s1_raw_q[2];
      end
      CC_RGBA: begin
        r = div255(s1_prod_q[0]);
        g = div255(s1_prod_q[1]);
        b = div255(s1_prod_q[2]);
      end
      default: begin
        r = '0;
        g = '0;
        b = '0;
      end
    endcase
  end

  // max 255 * 1000 fits in LUMA_W bits
  assign push_data_o.kind        = s1_kind_q;
  assign push_data_o.frame_start = s1_start_q;
  assign push_data_o.luma        = LUMA_W'(r) * WEIGHT_R + LUMA_W'(g) * WEIGHT_G
                                 + LUMA_W'(b) * WEIGHT_B;

endmodule

### hdl/lcs_queue.sv
// Small FIFO of classified luma entries between front and back end.
module lcs_queue import lcs_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  lcs_entry_t push_data_i,
  input  logic       pop_i,
  output lcs_entry_t pop_data_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lcs_entry_t       mem_q [DEPTH];
  logic [IDX_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  function automatic logic [IDX_W-1:0] next_ptr(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue pop while empty");

endmodule

### hdl/lcs_back.sv
// Back end: min/max tracking, stretch mapping with restoring divider, output register.
module lcs_back import lcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lcs_entry_t pop_data_i,
  input  logic       empty_i,
  output logic       pop_o,
  lcs_gray_if.source gray_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SAT,
    S_DIV,
    S_EMIT
  } state_e;

  state_e            state_q;
  logic [LUMA_W-1:0] min_q, max_q;
  logic [LUMA_W-1:0] off_q, span_q;
  logic [DIV_W-1:0]  rem_q, dvs_q;
  logic [STEP_W-1:0] step_q;
  logic [GRAY_W-1:0] quo_q;
  logic              out_valid_q;
  logic [GRAY_W-1:0] out_q;

  logic [LUMA_W-1:0] base_min, base_max, luma;
  logic [DIV_W-1:0]  trial;
  logic              out_free;
  logic              out_load;

  assign pop_o    = (state_q == S_IDLE) && !empty_i;
  assign luma     = pop_data_i.luma;
  assign base_min = pop_data_i.frame_start ? LUMA_ALL_ONES : min_q;
  assign base_max = pop_data_i.frame_start ? '0 : max_q;
  assign trial    = dvs_q << step_q;
  assign out_free = !out_valid_q || gray_o.ready;
  assign out_load = (state_q == S_EMIT) && out_free;

  assign gray_o.valid      = out_valid_q;
  assign gray_o.gray_level = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      min_q       <= LUMA_ALL_ONES;
      max_q       <= '0;
      out_valid_q <= 1'b0;
      off_q       <= '0;
      span_q      <= '0;
      rem_q       <= '0;
      dvs_q       <= '0;
      step_q      <= '0;
      quo_q       <= '0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && gray_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            if (pop_data_i.kind == KIND_GATHER) begin
              min_q <= (luma < base_min) ? luma : base_min;
              max_q <= (luma > base_max) ? luma : base_max;
            end else if (luma < min_q) begin
              quo_q   <= '0;
              state_q <= S_EMIT;
            end else begin
              off_q   <= luma - min_q;
              span_q  <= (max_q > min_q) ? max_q - min_q : LUMA_W'(1);
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          // numerator 2*off*255 + span, divisor 2*span
          rem_q   <= DIV_W'(off_q) * MAP_SCALE + DIV_W'(span_q);
          dvs_q   <= DIV_W'(span_q) << 1;
          state_q <= S_SAT;
        end
        S_SAT: begin
          if (rem_q >= (dvs_q << GRAY_W)) begin
            quo_q   <= GRAY_MAX;
            state_q <= S_EMIT;
          end else begin
            quo_q   <= '0;
            step_q  <= STEP_W'(GRAY_W - 1);
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_q >= trial) begin
            rem_q         <= rem_q - trial;
            quo_q[step_q] <= 1'b1;
          end
          if (step_q == '0) begin
            state_q <= S_EMIT;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_q   <= quo_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // partial remainder stays below the current trial divisor doubled
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < (dvs_q << ({1'b0, step_q} + 4'd1))))
    else $error("divider remainder out of range");

  a_minmax_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && pop_data_i.kind == KIND_GATHER) |=> (min_q <= max_q))
    else $error("min above max after gather word");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free) |=> (out_valid_q && out_q == $past(quo_q)))
    else $error("result not loaded into output register");

endmodule

### hdl/luma_contrast_stretch.sv
// Top level of the luma contrast stretch: APB register, front end, queue, back end.
// Path: a gather word passes the front register and the queue, then updates min/max; a
//   map word goes S_IDLE to S_EMIT directly (luma below min), via S_MUL, S_SAT (saturated)
//   or via S_MUL, S_SAT, S_DIV (full divide, 8 quotient steps of the restoring divider).
// Gather words 1/cycle while the queue has room; the back end takes map words one at a time.
// Front end and back end stall independently through the entry queue.
// Reset (async, active low): channel_count = 3, min = all ones, max = 0, queue empty.
module luma_contrast_stretch import lcs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  lcs_pix_if.sink               pix_i,
  lcs_gray_if.source            gray_o
);

  logic [CC_W-1:0] channel_count_q;
  logic            reg_hit;

  lcs_entry_t push_data, pop_data;
  logic       push, pop, full, empty;

  // one 32-bit register at word index 0; other addresses read zero, ignore writes
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_CHANNEL_COUNT);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? APB_DATA_W'(channel_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_count_q <= CC_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      channel_count_q <= pwdata[CC_W-1:0];
    end
  end

  // alpha premultiply and luma
  lcs_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .channel_count_i (channel_count_q),
    .pix_i           (pix_i),
    .full_i          (full),
    .push_o          (push),
    .push_data_o     (push_data)
  );

  lcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (full),
    .empty_o     (empty)
  );

  // statistics update, stretch divide, output word register
  lcs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_data_i (pop_data),
    .empty_i    (empty),
    .pop_o      (pop),
    .gray_o     (gray_o)
  );

endmodule

### dv/luma_contrast_stretch_tb.sv
// Self-checking testbench for luma_contrast_stretch: directed rows, then random frames.
`timescale 1ns / 1ps

module luma_contrast_stretch_tb;
  import lcs_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 6;
  // Gather words pass the front register and the queue and leave no result,
  // so wait this long before touching the register once nothing is pending.
  localparam int SETTLE_CYCLES = 20;
  localparam int STALL_LIMIT   = 4000;
  localparam int FRAME_MAX     = 16;
  localparam int PHASE_WORDS   = 140;
  localparam int PHASES        = 12;
  localparam int unsigned SAMPLE_FULL = 255;

  // Channel counts that select no format: luma is forced to zero.
  localparam logic [CC_W-1:0] CC_NONE_0 = 3'd0;
  localparam logic [CC_W-1:0] CC_NONE_5 = 3'd5;
  localparam logic [CC_W-1:0] CC_NONE_6 = 3'd6;
  localparam logic [CC_W-1:0] CC_NONE_7 = 3'd7;

  localparam logic [APB_ADDR_W-1:0] ADDR_CHANNEL_COUNT = {REG_CHANNEL_COUNT, 2'b00};

  // Packed pixel, element c is sample c: written as {s3, s2, s1, s0}.
  typedef logic [3:0][SAMPLE_W-1:0] pixel_t;

  typedef struct packed {
    logic              kind;
    logic              frame_start;
    pixel_t            px;
    logic              fixed;  // 1: gray below is the known answer
    logic [GRAY_W-1:0] gray;
  } stim_row_t;

  // Directed rows, all under the reset format (RGB).
  localparam stim_row_t DIR_ROWS [21] = '{
    // no statistics gathered yet: minimum is all ones, so anything maps to 0
    '{KIND_MAP,    1'b0, {8'd0,   8'd255, 8'd255, 8'd255}, 1'b1, 8'd0},
    // first gather of a frame; alpha sample is unused for RGB
    '{KIND_GATHER, 1'b1, {8'd255, 8'd0,   8'd0,   8'd0},   1'b0, 8'd0},
    '{KIND_MAP,    1'b0, {8'd0,   8'd0,   8'd0,   8'd0},   1'b1, 8'd0},
    // flat statistics: span is 1, any step above the minimum saturates
    '{KIND_MAP,    1'b0, {8'd255, 8'd0,   8'd0,   8'd1},   1'b1, 8'd255},
    '{KIND_GATHER, 1'b0, {8'd0,   8'd255, 8'd255, 8'd255}, 1'b0, 8'd0},
    '{KIND_MAP,    1'b0, {8'd0,   8'd255, 8'd255, 8'd255}, 1'b1, 8'd255},
    '{KIND_MAP,    1'b0, {8'd255, 8'd0,   8'd0,   8'd0},   1'b1, 8'd0},
    '{KIND_MAP,    1'b0, {8'd0,   8'd128, 8'd128, 8'd128}, 1'b0, 8'd0},
    // new frame, narrower range
    '{KIND_GATHER, 1'b1, {8'd0,   8'd100, 8'd100, 8'd100}, 1'b0, 8'd0},
    '{KIND_GATHER, 1'b0, {8'd255, 8'd200, 8'd200, 8'd200}, 1'b0, 8'd0},
    // below minimum, above maximum, frame_start ignored in map pass
    '{KIND_MAP,    1'b0, {8'd0,   8'd50,  8'd50,  8'd50},  1'b1, 8'd0},
    '{KIND_MAP,    1'b0, {8'd0,   8'd255, 8'd255, 8'd255}, 1'b1, 8'd255},
    '{KIND_MAP,    1'b1, {8'd0,   8'd200, 8'd200, 8'd200}, 1'b1, 8'd255},
    '{KIND_MAP,    1'b0, {8'd255, 8'd100, 8'd100, 8'd100}, 1'b1, 8'd0},
    '{KIND_MAP,    1'b0, {8'd99,  8'd3,   8'd200, 8'd17},  1'b0, 8'd0},
    '{KIND_MAP,    1'b0, {8'd0,   8'd150, 8'd150, 8'd150}, 1'b0, 8'd0},
    '{KIND_MAP,    1'b0, {8'd0,   8'd0,   8'd0,   8'd255}, 1'b1, 8'd0},
    '{KIND_MAP,    1'b0, {8'd0,   8'd0,   8'd255, 8'd0},   1'b0, 8'd0},
    // single-pixel frame: min equals max
    '{KIND_GATHER, 1'b1, {8'd0,   8'd0,   8'd0,   8'd255}, 1'b0, 8'd0},
    '{KIND_MAP,    1'b0, {8'd0,   8'd0,   8'd0,   8'd255}, 1'b1, 8'd0},
    '{KIND_MAP,    1'b0, {8'd0,   8'd0,   8'd255, 8'd0},   1'b1, 8'd255}
  };

  // Format per random phase; extremes and the dead codes included.
  localparam logic [CC_W-1:0] PHASE_CC [PHASES] = '{
    CC_GRAY, CC_GRAY_ALPHA, CC_RGB, CC_RGBA,
    CC_NONE_0, CC_RGBA, CC_GRAY_ALPHA, CC_NONE_7,
    CC_NONE_6, CC_GRAY, CC_NONE_5, CC_RGB
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  lcs_pix_if  pix_if ();
  lcs_gray_if gray_if ();

  // Predictor copy of the block's state
  logic [CC_W-1:0]   chan_cfg;
  logic [LUMA_W-1:0] luma_lo;
  logic [LUMA_W-1:0] luma_hi;

  logic [GRAY_W-1:0] gray_pending [$];
  int err_count    = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  luma_contrast_stretch uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix_i   (pix_if),
    .gray_o  (gray_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned premul(input int unsigned c, input int unsigned a);
    return (c * a) / SAMPLE_FULL;
  endfunction

  function automatic logic [LUMA_W-1:0] pixel_luma(input pixel_t px);
    int unsigned r, g, b, sum;
    r = 0;
    g = 0;
    b = 0;
    case (chan_cfg)
      CC_GRAY: begin
        r = px[0]; g = r; b = r;
      end
      CC_GRAY_ALPHA: begin
        r = premul(px[0], px[1]); g = r; b = r;
      end
      CC_RGB: begin
        r = px[0]; g = px[1]; b = px[2];
      end
      CC_RGBA: begin
        r = premul(px[0], px[3]);
        g = premul(px[1], px[3]);
        b = premul(px[2], px[3]);
      end
      default: ;  // dead format codes give black
    endcase
    sum = WEIGHT_R * r + WEIGHT_G * g + WEIGHT_B * b;
    return sum[LUMA_W-1:0];
  endfunction

  // Gather words move the min/max; map words produce the stretched gray.
  task automatic take_pixel(input logic kind, input logic fs, input pixel_t px,
                            output logic has_res, output logic [GRAY_W-1:0] gray);
    logic [LUMA_W-1:0] luma;
    longint unsigned span, offset, q;
    luma    = pixel_luma(px);
    has_res = 1'b0;
    gray    = '0;
    if (kind == KIND_GATHER) begin
      if (fs) begin
        luma_lo = LUMA_ALL_ONES;
        luma_hi = '0;
      end
      if (luma < luma_lo) luma_lo = luma;
      if (luma > luma_hi) luma_hi = luma;
    end else begin
      has_res = 1'b1;
      if (luma >= luma_lo) begin
        span   = (luma_hi > luma_lo) ? longint'(luma_hi - luma_lo) : 1;
        offset = longint'(luma - luma_lo);
        // round half up, then clamp at white
        q      = (2 * offset * longint'(GRAY_MAX) + span) / (2 * span);
        gray   = (q > longint'(GRAY_MAX)) ? GRAY_MAX : q[GRAY_W-1:0];
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Pixel sender: drives at the falling edge, random gaps before each word
  // ---------------------------------------------------------------------------
  task automatic send_pixel(input logic kind, input logic fs, input pixel_t px,
                            output logic has_res, output logic [GRAY_W-1:0] gray);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      pix_if.valid = 1'b0;
      @(negedge clk_i);
    end
    pix_if.valid       = 1'b1;
    pix_if.kind        = kind;
    pix_if.frame_start = fs;
    pix_if.sample0     = px[0];
    pix_if.sample1     = px[1];
    pix_if.sample2     = px[2];
    pix_if.sample3     = px[3];
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    // word accepted at this edge: update the predictor right away
    take_pixel(kind, fs, px, has_res, gray);
  endtask

  task automatic send_checked(input logic kind, input logic fs, input pixel_t px);
    logic              has_res;
    logic [GRAY_W-1:0] gray;
    send_pixel(kind, fs, px, has_res, gray);
    if (has_res) gray_pending.push_back(gray);
  endtask

  // Drop valid and hold off until every gray word is back and the pipe is empty.
  task automatic settle();
    @(negedge clk_i);
    pix_if.valid = 1'b0;
    while (gray_pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // APB register access
  // ---------------------------------------------------------------------------
  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apb_read(input logic [APB_ADDR_W-1:0] addr,
                          output logic [APB_DATA_W-1:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    data = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_channels(input logic [CC_W-1:0] want);
    logic [APB_DATA_W-1:0] got;
    apb_read(ADDR_CHANNEL_COUNT, got);
    if (got !== APB_DATA_W'(want)) begin
      $error("channel_count readback: expected %0d, actual %0d", want, got);
      err_count++;
    end
  endtask

  task automatic set_channels(input logic [CC_W-1:0] cc);
    apb_write(ADDR_CHANNEL_COUNT, APB_DATA_W'(cc));
    chan_cfg = cc;
    check_channels(cc);
  endtask

  // ---------------------------------------------------------------------------
  // Random part: mostly whole frames (gather pass then map pass over the same
  // pixels), with stray words mixed in. Frames vary in size, spread and alpha.
  // ---------------------------------------------------------------------------
  task automatic run_random(input int quota);
    pixel_t frame [FRAME_MAX];
    pixel_t base;
    int     sent, n, spread, alpha_slot, alpha_pick, v;
    logic   backward;
    sent       = 0;
    alpha_slot = (chan_cfg == CC_GRAY_ALPHA) ? 1 : 3;
    while (sent < quota) begin
      if ($urandom_range(0, 99) < 20) begin
        // stray word: either pass, frame_start anywhere, any samples
        send_checked(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
        sent++;
      end else begin
        n    = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, FRAME_MAX);
        base = $urandom();
        case ($urandom_range(0, 3))
          0:       spread = 0;    // flat frame
          1:       spread = 3;    // tiny span, rounding matters
          2:       spread = 40;
          default: spread = 255;  // full range
        endcase
        alpha_pick = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) begin
          for (int c = 0; c < 4; c++) begin
            if (spread == 255) begin
              frame[i][c] = SAMPLE_W'($urandom_range(0, 255));
            end else begin
              v = base[c] + $urandom_range(0, spread);
              frame[i][c] = (v > 255) ? 8'hFF : SAMPLE_W'(v);
            end
          end
          if (alpha_pick == 0) frame[i][alpha_slot] = 8'hFF;  // opaque
          else if (alpha_pick == 1) frame[i][alpha_slot] = 8'h00;  // transparent
        end
        backward = 1'($urandom_range(0, 1));
        for (int i = 0; i < n; i++)
          send_checked(KIND_GATHER, i == 0, frame[i]);
        for (int i = 0; i < n; i++)
          send_checked(KIND_MAP, 1'($urandom_range(0, 1)), frame[backward ? n - 1 - i : i]);
        sent += 2 * n;
        // occasional random map word, which may fall outside the gathered range
        if ($urandom_range(0, 3) == 0) begin
          send_checked(KIND_MAP, 1'b0, $urandom());
          sent++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Gray receiver: ready toggles at the falling edge, words checked at rising
  // ---------------------------------------------------------------------------
  initial begin
    gray_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      gray_if.ready = ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : gray_check
    logic [GRAY_W-1:0] want;
    if (rst_ni && gray_if.valid && gray_if.ready) begin
      if (gray_pending.size() == 0) begin
        $error("gray_level %0d arrived with no word pending", gray_if.gray_level);
        err_count++;
      end else begin
        want = gray_pending.pop_front();
        if (gray_if.gray_level !== want) begin
          $error("gray_level: expected %0d, actual %0d", want, gray_if.gray_level);
          err_count++;
        end
      end
    end
  end

  // Ends the run if no word moves on any port for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((pix_if.valid && pix_if.ready) || (gray_if.valid && gray_if.ready) ||
          (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic              has_res;
    logic [GRAY_W-1:0] gray;
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    pix_if.valid       = 1'b0;
    pix_if.kind        = KIND_GATHER;
    pix_if.frame_start = 1'b0;
    pix_if.sample0     = '0;
    pix_if.sample1     = '0;
    pix_if.sample2     = '0;
    pix_if.sample3     = '0;
    chan_cfg           = CC_RESET;
    luma_lo            = LUMA_ALL_ONES;
    luma_hi            = '0;
    snd_idle_pct       = 19;
    rcv_idle_pct       = 61;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    check_channels(CC_RESET);

    // directed rows: known answers where obvious, predictor otherwise
    foreach (DIR_ROWS[i]) begin
      send_pixel(DIR_ROWS[i].kind, DIR_ROWS[i].frame_start, DIR_ROWS[i].px, has_res, gray);
      if (has_res) gray_pending.push_back(DIR_ROWS[i].fixed ? DIR_ROWS[i].gray : gray);
    end
    settle();

    // random phases: slow receiver, then slow sender, then full speed
    for (int p = 0; p < PHASES; p++) begin
      case (p / 4)
        0: begin
          snd_idle_pct = 19; rcv_idle_pct = 61;
        end
        1: begin
          snd_idle_pct = 61; rcv_idle_pct = 19;
        end
        default: begin
          snd_idle_pct = 0; rcv_idle_pct = 0;
        end
      endcase
      set_channels(PHASE_CC[p]);
      run_random(PHASE_WORDS);
      settle();
    end

    if (err_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
hdl/lcs_pkg.sv
hdl/lcs_if.sv
hdl/lcs_front.sv
hdl/lcs_queue.sv
hdl/lcs_back.sv
hdl/luma_contrast_stretch.sv
dv/luma_contrast_stretch_tb.sv
